// File: src/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// shared types and constants of the counting sort engine
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int VALUE_W         = 8;
    localparam int VALUE_RANGE_DEF = 256;
    localparam int MAX_ITEMS_DEF   = 64;

    // input word
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               end_of_run;
        logic               overflowed;
    } out_word_t;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_INC   = 6'b000100,
        ST_BEGIN = 6'b001000,
        ST_FETCH = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

endpackage

// File: src/cse_ram.sv
// ----------------------------------------------------------------------------
// cse_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/counting_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// counting_sort_engine_unit
// counting sort of small values: tallies a set into a histogram ram, then
// walks the histogram upward and emits each value as often as it was counted
// ----------------------------------------------------------------------------
//
//  channel   ports                  handshake
//  --------  ---------------------  -----------------------------------------
//  input     item (value, last)     word taken when start && !busy
//  result    result (sorted_value,  word valid for one cycle with strobe,
//            end_of_run,            no back-pressure
//            overflowed)
//
//  a tallied value is read from the histogram, then its count is written back
//  +1; a dropped value that is not last leaves the block idle
//  on a last word of a nonempty set emission walks the bins upward from zero,
//  reading each bin and emitting one word per counted copy of its value; the
//  walk stops after the last counted value and clears each bin as it reads it
//  after reset a clearing pass writes zero to all min(VALUE_RANGE,256) bins,
//  with busy high
//  results leave a register in the cycle after they are formed; the receiver
//  cannot stall, so the walk never waits
// ----------------------------------------------------------------------------
module counting_sort_engine_unit #(
    parameter int VALUE_RANGE = cse_pkg::VALUE_RANGE_DEF,
    parameter int MAX_ITEMS   = cse_pkg::MAX_ITEMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cse_pkg::in_word_t  item,
    output logic               strobe,
    output cse_pkg::out_word_t result
);

    import cse_pkg::*;

    // only values below 2**VALUE_W can ever arrive
    localparam int BINS   = (VALUE_RANGE < (1 << VALUE_W)) ? VALUE_RANGE : (1 << VALUE_W);
    localparam int ADDR_W = $clog2(BINS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  bin_reg, bin_next;      // walk pointer, or bin being tallied
    logic [CNT_W-1:0]   held_reg, held_next;    // values tallied in this set
    logic [CNT_W-1:0]   sent_reg, sent_next;    // words emitted so far
    logic [CNT_W-1:0]   rep_reg, rep_next;      // copies of current bin still to emit
    logic               drop_reg, drop_next;
    logic               last_reg, last_next;
    logic               strobe_reg, strobe_next;
    out_word_t          result_reg, result_next;

    // histogram ram ports
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CNT_W-1:0]   ram_rdata;

    logic               accept;
    logic               keep;                   // value goes into the histogram

    cse_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BINS)
    ) u_tally (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);
    assign keep   = (32'(item.value) < VALUE_RANGE) && (held_reg != CNT_W'(MAX_ITEMS));

    // write port always targets bin_reg
    assign ram_waddr = bin_reg;

    // read address: incoming value when idle, else bin_next (the next bin of the walk)
    assign ram_raddr = (state_reg == ST_IDLE) ? item.value[ADDR_W-1:0] : bin_next;

    assign strobe = strobe_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        bin_next    = bin_reg;
        held_next   = held_reg;
        sent_next   = sent_reg;
        rep_next    = rep_reg;
        drop_next   = drop_reg;
        last_next   = last_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_wdata   = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                bin_next = bin_reg + 1'b1;
                if (bin_reg == ADDR_W'(BINS - 1))
                begin
                    bin_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = item.last;
                    if (keep)
                    begin
                        bin_next   = item.value[ADDR_W-1:0];
                        state_next = ST_INC;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                        if (item.last)
                        begin
                            state_next = ST_BEGIN;
                        end
                    end
                end
            end
            ST_INC:
            begin
                // read data of the bin arrives here, write back count + 1
                ram_we    = 1'b1;
                ram_wdata = ram_rdata + 1'b1;
                held_next = held_reg + 1'b1;
                state_next = last_reg ? ST_BEGIN : ST_IDLE;
            end
            ST_BEGIN:
            begin
                if (held_reg == '0)
                begin
                    // empty set: nothing tallied, just reset set state
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    bin_next   = '0;
                    sent_next  = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // clear the bin as it is read
                ram_we = 1'b1;
                if (ram_rdata == '0)
                begin
                    bin_next = bin_reg + 1'b1;
                end
                else
                begin
                    rep_next   = ram_rdata;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next              = 1'b1;
                result_next.sorted_value = VALUE_W'(bin_reg);
                result_next.end_of_run   = (sent_reg + 1'b1 == held_reg);
                result_next.overflowed   = drop_reg;
                sent_next                = sent_reg + 1'b1;
                rep_next                 = rep_reg - 1'b1;
                if (sent_reg + 1'b1 == held_reg)
                begin
                    // every counted value sent, later bins are already zero
                    held_next  = '0;
                    sent_next  = '0;
                    drop_next  = 1'b0;
                    bin_next   = '0;
                    state_next = ST_IDLE;
                end
                else if (rep_reg == CNT_W'(1))
                begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            bin_reg    <= '0;
            held_reg   <= '0;
            sent_reg   <= '0;
            rep_reg    <= '0;
            drop_reg   <= 1'b0;
            last_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bin_reg    <= bin_next;
            held_reg   <= held_next;
            sent_reg   <= sent_next;
            rep_reg    <= rep_next;
            drop_reg   <= drop_next;
            last_reg   <= last_next;
            strobe_reg <= strobe_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// File: tb/counting_sort_engine_checker.sv
// ----------------------------------------------------------------------------
// counting_sort_engine_checker
// watches the item and result channels of the counting sort engine, keeps
// its own histogram of each set and compares every sorted word in order
// ----------------------------------------------------------------------------
module counting_sort_engine_checker #(
    parameter int VALUE_RANGE = cse_pkg::VALUE_RANGE_DEF,
    parameter int MAX_ITEMS   = cse_pkg::MAX_ITEMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  cse_pkg::in_word_t  item,
    input  logic               strobe,
    input  cse_pkg::out_word_t result,
    output int                 fail_count,
    output int                 pending,
    output int                 sets_closed,
    output int                 overflow_sets,
    output int                 words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    localparam int PRINT_CAP = 30;

    bit [6:0]  bin_count [VALUE_RANGE];
    bit [6:0]  set_count;
    bit        set_dropped;
    out_word_t sorted_expect_q [$];
    out_word_t want;

    task automatic report_mismatch(input string msg);
        fail_count++;
        // keep the log short when the design is badly off
        if (fail_count <= PRINT_CAP)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic clear_set_state();
        foreach (bin_count[b])
            bin_count[b] = '0;
        set_count   = '0;
        set_dropped = 1'b0;
    endtask

    // tally one accepted word; a last word queues the whole sorted set
    task automatic tally_word(input in_word_t w);
        out_word_t r;
        int        total;
        int        emitted;
        if (w.value >= VALUE_RANGE || set_count >= MAX_ITEMS)
            set_dropped = 1'b1;
        else
        begin
            bin_count[w.value] = bin_count[w.value] + 7'd1;
            set_count          = set_count + 7'd1;
        end
        if (w.last)
        begin
            total   = set_count;
            emitted = 0;
            for (int b = 0; b < VALUE_RANGE; b++)
            begin
                for (int c = 0; c < bin_count[b] && emitted < MAX_ITEMS; c++)
                begin
                    r.sorted_value = VALUE_W'(b);
                    r.end_of_run   = (emitted + 1 == total);
                    r.overflowed   = set_dropped;
                    sorted_expect_q.push_back(r);
                    emitted++;
                end
            end
            sets_closed++;
            if (set_dropped)
                overflow_sets++;
            clear_set_state();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_set_state();
            sorted_expect_q.delete();
            pending <= 0;
        end
        else
        begin
            // a result word leaving at this edge is checked before a new item
            if (strobe)
            begin
                if (sorted_expect_q.size() == 0)
                    report_mismatch($sformatf("unexpected word value=%0d end=%0b ovf=%0b",
                        result.sorted_value, result.end_of_run, result.overflowed));
                else
                begin
                    want = sorted_expect_q.pop_front();
                    if (result.sorted_value !== want.sorted_value)
                        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                            result.sorted_value, want.sorted_value));
                    if (result.end_of_run !== want.end_of_run)
                        report_mismatch($sformatf("end_of_run %0b, expected %0b (value %0d)",
                            result.end_of_run, want.end_of_run, want.sorted_value));
                    if (result.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed %0b, expected %0b (value %0d)",
                            result.overflowed, want.overflowed, want.sorted_value));
                    words_checked++;
                end
            end
            if (start && !busy)
                tally_word(item);
            pending <= sorted_expect_q.size();
        end
    end

endmodule

// File: tb/counting_sort_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// counting_sort_engine_unit_tb
// drives sets of values into the counting sort engine with random gaps and
// gives the verdict; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module counting_sort_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    // longest quiet stretch of a correct run is the clearing pass or one
    // histogram walk; this is many times that
    localparam int WATCHDOG_LIMIT = 5000;
    // quiet cycles after the last sorted word, to catch late strays
    localparam int TAIL_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 220;

    // how the values of a random set are drawn
    typedef enum int {
        MIX_FULL,     // anywhere in 0..255
        MIX_NARROW,   // a window of 8 values, lots of duplicates
        MIX_EDGES     // near 0 or near 255
    } value_mix_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  item  = '0;
    logic      busy;
    logic      strobe;
    out_word_t result;

    int fail_count;
    int pending;
    int sets_closed;
    int overflow_sets;
    int words_checked;
    int items_sent;
    int idle_cycles;
    bit no_gaps;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    counting_sort_engine_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    counting_sort_engine_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .strobe        (strobe),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .sets_closed   (sets_closed),
        .overflow_sets (overflow_sets),
        .words_checked (words_checked)
    );

    // offer one word and hold it until busy is sampled low; start stays high
    // on return so back-to-back words need no extra assignment
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic lst);
        // random gaps, a chance of 16 in 100 per draw, skipped in burst stretches
        while (!no_gaps && $urandom_range(99) < 16)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{value: v, last: lst};
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // one whole set of n words, last flag on the final one
    task automatic send_set(input int n, input value_mix_t mix);
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] v;
        base = VALUE_W'($urandom_range(255));
        for (int i = 0; i < n; i++)
        begin
            case (mix)
                MIX_NARROW: v = base + VALUE_W'($urandom_range(7));
                MIX_EDGES:  v = $urandom_range(1) ? VALUE_W'($urandom_range(3))
                                                  : VALUE_W'(255 - $urandom_range(3));
                default:    v = VALUE_W'($urandom_range(255));
            endcase
            send_word(v, i == n - 1);
        end
    endtask

    // stop offering until every predicted word has come out
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // watchdog: ends the run if no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles, %0d words still due",
                    WATCHDOG_LIMIT, pending);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] dup_set [6];
        logic [VALUE_W-1:0] bit_set [8];
        int                 random_target;
        int                 pick;
        value_mix_t         mix;

        dup_set = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd1};
        bit_set = '{8'hAA, 8'h55, 8'hFF, 8'h00, 8'h0F, 8'hF0, 8'h80, 8'h01};

        // reset once; the block then runs its clearing pass with busy high
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed sets ----
        // single-word sets at both ends of the range
        send_word(8'd255, 1'b1);
        send_word(8'd0, 1'b1);
        // extremes with duplicates, out of order
        foreach (dup_set[i])
            send_word(dup_set[i], i == 5);
        // every bit of the value at both levels
        foreach (bit_set[i])
            send_word(bit_set[i], i == 7);
        // one value repeated, all words of a single bin
        for (int i = 0; i < 4; i++)
            send_word(8'd7, i == 3);
        drain();

        // ---- random sets ----
        random_target = items_sent + RANDOM_ITEMS;

        // capacity exactly reached: 64 words, no drop; sent as one burst
        no_gaps = 1'b1;
        send_set(MAX_ITEMS_DEF, MIX_FULL);
        no_gaps = 1'b0;
        // capacity overrun: one extra word dropped, then a last word that is
        // dropped too but still starts the walk
        for (int i = 0; i < MAX_ITEMS_DEF + 2; i++)
            send_word(VALUE_W'($urandom_range(255)), i == MAX_ITEMS_DEF + 1);
        drain();

        while (items_sent < random_target)
        begin
            pick = $urandom_range(99);
            mix  = value_mix_t'($urandom_range(2));
            // mostly short sets, some medium, a few near or over capacity
            if (pick < 70)
                send_set($urandom_range(1, 10), mix);
            else if (pick < 85)
                send_set($urandom_range(11, 40), mix);
            else
                send_set($urandom_range(60, 70), mix);
            if ($urandom_range(9) == 0)
                drain();
        end

        // ---- wind down ----
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d words in %0d sets, %0d of them over capacity",
            items_sent, sets_closed, overflow_sets);
        $display("checked %0d sorted words, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
